// ===== hdl/dmix_pkg.sv =====
// Shared types, constants and helper functions for the diffusion mixer.
// No dependencies; used by dmix_cell and diffusion_mix_256.
`timescale 1ns / 1ps

package dmix_pkg;

    localparam int WordW    = 64;
    localparam int NumWords = 4;
    localparam int NumRounds = 9;
    localparam int StepsPerRound = 4;
    localparam int NumSteps = NumRounds * StepsPerRound;
    localparam int StepW    = 6;
    localparam int RotW     = 6;
    localparam int WordIdxW = 2;
    localparam int RoundW   = 4;

    typedef logic [WordW-1:0] word_t;
    typedef word_t [NumWords-1:0] words_t;

    // Per-cell control: which word is updated, which word is added in,
    // and the rotation that closes a round.
    typedef struct packed {
        logic [WordIdxW-1:0] dst;
        logic [WordIdxW-1:0] src;
        logic                rot_en;
        logic [NumWords-1:0] rot_mask;
        logic [RotW-1:0]     rot_amt;
    } step_t;

    localparam logic [RotW-1:0] RotAmt [NumRounds] = '{
        6'd1, 6'd2, 6'd1, 6'd3, 6'd7, 6'd16, 6'd31, 6'd58, 6'd0
    };

    localparam logic [NumWords-1:0] RotMask [NumRounds] = '{
        4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'h5, 4'h5, 4'h5, 4'h0
    };

    localparam logic [1:0] LastSub = 2'd3;

    function automatic word_t rotl(input word_t v, input logic [RotW-1:0] r);
        word_t res;
        if (r == '0)
        begin
            res = v;
        end
        else
        begin
            res = (v << r) | (v >> (7'(WordW) - {1'b0, r}));
        end
        return res;
    endfunction

    // Step index: upper bits give the round, lower two bits the add within it.
    function automatic step_t mix_step(input logic [StepW-1:0] idx);
        step_t s;
        logic [RoundW-1:0] rnd;
        logic [1:0]        sub;
        rnd = idx[StepW-1:2];
        sub = idx[1:0];
        if (sub == LastSub)
        begin
            s.dst = 2'd0;
            s.src = 2'd3;
        end
        else
        begin
            s.dst = sub + 2'd1;
            s.src = sub;
        end
        s.rot_en   = (sub == LastSub);
        s.rot_mask = RotMask[rnd];
        s.rot_amt  = RotAmt[rnd];
        return s;
    endfunction

endpackage

// ===== hdl/dmix_cell.sv =====
// One cell of the mixing chain: a single wrapping add, plus the round's
// rotation on the last add of a round. Depends on dmix_pkg.
`timescale 1ns / 1ps

module dmix_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  dmix_pkg::step_t   step,
    input  logic              up_valid,
    output logic              up_ready,
    input  dmix_pkg::words_t  up_words,
    output logic              down_valid,
    input  logic              down_ready,
    output dmix_pkg::words_t  down_words
);

    logic             valid_reg;
    logic             valid_next;
    dmix_pkg::words_t words_reg;
    dmix_pkg::words_t words_next;
    dmix_pkg::words_t mixed;
    dmix_pkg::word_t  sum;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_words = words_reg;

    assign sum = up_words[step.dst] + up_words[step.src];

    always_comb
    begin
        mixed = up_words;
        mixed[step.dst] = sum;
        if (step.rot_en)
        begin
            for (int k = 0; k < dmix_pkg::NumWords; k++)
            begin
                if (step.rot_mask[k])
                begin
                    mixed[k] = dmix_pkg::rotl(mixed[k], step.rot_amt);
                end
            end
        end
    end

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        words_next = (up_ready && up_valid) ? mixed : words_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

endmodule

// ===== hdl/diffusion_mix_256.sv =====
// Top level of the 256-bit diffusion mixer: a chain of 36 dmix_cell stages.
// Depends on dmix_pkg and dmix_cell.
`timescale 1ns / 1ps

// diffusion_mix_256 mixes one 256-bit block, given as four little-endian
// 64-bit words, through nine rounds of chained wrapping adds and rotations.
// Each round is split into its four dependent adds, and each add is one
// cell of a 36-cell pipeline, so a cell holds one 64-bit adder and the
// constant rotation wiring. The block takes one item per cycle until
// back-pressure from the output has filled every cell. An accepted item
// passes through the registers of all 36 cells in order, one register
// per serial add, before it reaches the output. Every cell holds its
// own item and valid bit and passes it on as soon as the next cell is
// free, so the chain keeps accepting items while a finished result
// waits at the output, until all 36 cells are full. There is no
// configuration and no state beyond the items in flight; reset only
// drops them.

module diffusion_mix_256 (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [63:0]           word0_in,
    input  logic [63:0]           word1_in,
    input  logic [63:0]           word2_in,
    input  logic [63:0]           word3_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [63:0]           word0_out,
    output logic [63:0]           word1_out,
    output logic [63:0]           word2_out,
    output logic [63:0]           word3_out
);

    localparam int N = dmix_pkg::NumSteps;

    // Link g feeds cell g; link N is the output.
    logic             link_valid [N+1];
    logic             link_ready [N+1];
    dmix_pkg::words_t link_words [N+1];

    assign link_valid[0] = in_valid;
    assign in_ready      = link_ready[0];
    assign link_words[0] = {word3_in, word2_in, word1_in, word0_in};

    assign out_valid     = link_valid[N];
    assign link_ready[N] = out_ready;
    assign word0_out     = link_words[N][0];
    assign word1_out     = link_words[N][1];
    assign word2_out     = link_words[N][2];
    assign word3_out     = link_words[N][3];

    // Build the chain; each cell gets its fixed add and rotation from the package.
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        dmix_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .step       (dmix_pkg::mix_step(dmix_pkg::StepW'(g))),
            .up_valid   (link_valid[g]),
            .up_ready   (link_ready[g]),
            .up_words   (link_words[g]),
            .down_valid (link_valid[g+1]),
            .down_ready (link_ready[g+1]),
            .down_words (link_words[g+1])
        );
    end

endmodule
